[design/cuw_pkg.sv]
`default_nettype none

package cuw_pkg;

    localparam int UID_W        = 56;
    localparam int MODE_W       = 2;
    localparam int LEN_W        = 3;
    localparam int TYPE_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int SLOT_W       = 3;
    localparam int USER_SLOTS_DEF = 5;

    localparam logic [UID_W-1:0] MASTER_RESET = 56'h0000_0023_C893_CD;

    localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [LEN_W-1:0] LEN_SHORT = 3'd4;
    localparam logic [LEN_W-1:0] LEN_LONG  = 3'd7;

    localparam logic [TYPE_W-1:0] CT_UNKNOWN = 2'd0;
    localparam logic [TYPE_W-1:0] CT_USER    = 2'd1;
    localparam logic [TYPE_W-1:0] CT_MASTER  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // token that walks the row of slot cells
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } tok_t;

    // operation broadcast to every cell while an item is in flight
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [UID_W-1:0]  key;
        logic [UID_W-1:0]  wdata;
    } op_t;

endpackage

`default_nettype wire

[design/cuw_cell.sv]
`default_nettype none

module cuw_cell #(
    parameter logic [cuw_pkg::SLOT_W-1:0] SLOT_CODE = '0
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cuw_pkg::op_t  op,
    input  wire cuw_pkg::tok_t tok_in,
    output cuw_pkg::tok_t      tok_out
);

    logic [cuw_pkg::UID_W-1:0] entry_reg;
    logic [cuw_pkg::UID_W-1:0] entry_next;
    cuw_pkg::tok_t             tok_reg;
    cuw_pkg::tok_t             tok_next;
    logic                      match;
    logic                      wr_en;

    // first cell along the row holding the key claims the token
    assign match = tok_in.valid && !tok_in.hit && (entry_reg == op.key);
    assign wr_en = match && ((op.mode == cuw_pkg::MODE_ADD) ||
                             (op.mode == cuw_pkg::MODE_REMOVE));

    always_comb
    begin
        entry_next     = wr_en ? op.wdata : entry_reg;
        tok_next.valid = tok_in.valid;
        tok_next.hit   = tok_in.hit | match;
        tok_next.slot  = match ? SLOT_CODE : tok_in.slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

[design/card_uid_whitelist_top.sv]
`default_nettype none

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------
// item     | in        | start & !busy        | mode, uid, uid_length
// result   | out       | done (one cycle)     | card_type, status, slot
// config   | in        | cfg_valid & cfg_ready| cfg_data (master UID)
//
// An item walks the row of slot cells, one cell per cycle: the launch register,
// then one token register per cell, then the done register; busy stays high
// until the result strobe. A new item may be started in the cycle the result
// is shown.
// Reset clears every slot and loads the default master UID.
// The receiver cannot stall; cfg_ready is low while an item is in flight or
// while start is raised, so a write never lands on the edge an item is taken.

module card_uid_whitelist_top #(
    parameter int USER_SLOTS = cuw_pkg::USER_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [cuw_pkg::MODE_W-1:0]    mode,
    input  wire logic [cuw_pkg::UID_W-1:0]     uid,
    input  wire logic [cuw_pkg::LEN_W-1:0]     uid_length,
    output logic                               done,
    output logic [cuw_pkg::TYPE_W-1:0]         card_type,
    output logic [cuw_pkg::STATUS_W-1:0]       status,
    output logic [cuw_pkg::SLOT_W-1:0]         slot,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cuw_pkg::UID_W-1:0]     cfg_data
);

    logic                            busy_reg;
    logic                            busy_next;
    logic                            launch_reg;
    logic                            done_reg;
    logic [cuw_pkg::MODE_W-1:0]      mode_reg;
    logic [cuw_pkg::UID_W-1:0]       uid_reg;
    logic [cuw_pkg::LEN_W-1:0]       len_reg;
    logic [cuw_pkg::UID_W-1:0]       master_reg;
    logic [cuw_pkg::TYPE_W-1:0]      card_type_reg;
    logic [cuw_pkg::TYPE_W-1:0]      card_type_next;
    logic [cuw_pkg::STATUS_W-1:0]    status_reg;
    logic [cuw_pkg::STATUS_W-1:0]    status_next;
    logic [cuw_pkg::SLOT_W-1:0]      slot_reg;
    logic [cuw_pkg::SLOT_W-1:0]      slot_next;
    logic                            accept;
    cuw_pkg::op_t                    op;
    cuw_pkg::tok_t                   tok_chain [USER_SLOTS+1];
    cuw_pkg::tok_t                   tok_last;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg && !start;

    // add looks for an empty slot, remove for the uid itself
    assign op.mode  = mode_reg;
    assign op.key   = (mode_reg == cuw_pkg::MODE_ADD) ? '0 : uid_reg;
    assign op.wdata = (mode_reg == cuw_pkg::MODE_ADD) ? uid_reg : '0;

    assign tok_chain[0].valid = launch_reg;
    assign tok_chain[0].hit   = 1'b0;
    assign tok_chain[0].slot  = '0;

    genvar i;
    generate
        for (i = 0; i < USER_SLOTS; i++)
        begin : g_cell
            cuw_cell #(
                .SLOT_CODE(cuw_pkg::SLOT_W'(i))
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .op     (op),
                .tok_in (tok_chain[i]),
                .tok_out(tok_chain[i+1])
            );
        end
    endgenerate

    assign tok_last = tok_chain[USER_SLOTS];

    always_comb
    begin
        card_type_next = cuw_pkg::CT_UNKNOWN;
        status_next    = cuw_pkg::ST_DONE;
        slot_next      = '0;
        case (mode_reg)
            cuw_pkg::MODE_CHECK:
            begin
                if ((len_reg == cuw_pkg::LEN_SHORT) || (len_reg == cuw_pkg::LEN_LONG))
                begin
                    if (uid_reg == master_reg)
                        card_type_next = cuw_pkg::CT_MASTER;
                    else if (tok_last.hit)
                        card_type_next = cuw_pkg::CT_USER;
                end
            end
            cuw_pkg::MODE_ADD:
            begin
                if (tok_last.hit)
                    slot_next = tok_last.slot;
                else
                    status_next = cuw_pkg::ST_FULL;
            end
            cuw_pkg::MODE_REMOVE:
            begin
                if (tok_last.hit)
                    slot_next = tok_last.slot;
                else
                    status_next = cuw_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                card_type_next = cuw_pkg::CT_UNKNOWN;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (tok_last.valid)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
            master_reg <= cuw_pkg::MASTER_RESET;
        end
        else
        begin
            busy_reg   <= busy_next;
            launch_reg <= accept;
            done_reg   <= tok_last.valid;
            if (cfg_valid && cfg_ready)
                master_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            uid_reg  <= uid;
            len_reg  <= uid_length;
        end
        if (tok_last.valid)
        begin
            card_type_reg <= card_type_next;
            status_reg    <= status_next;
            slot_reg      <= slot_next;
        end
    end

    assign done      = done_reg;
    assign card_type = card_type_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result shown while still busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy not raised after accept");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("two results in a row");

    a_token_result: assert property (@(posedge clk) disable iff (!rst_n)
        tok_last.valid |=> done_reg)
        else $error("token left the row without a result");

    a_launch_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> $past(accept))
        else $error("token launched without an accepted item");

endmodule

`default_nettype wire
